>>> src/ttbd_pkg.sv
package ttbd_pkg;

  // table geometry: two trees, each TREE_ENTRIES deep
  localparam int TREE_ENTRIES = 512;
  localparam int IDX_W        = $clog2(TREE_ENTRIES);
  localparam int ADDR_W       = IDX_W + 1;
  localparam int RAM_DEPTH    = 2 * TREE_ENTRIES;
  localparam int ENTRY_W      = 9;
  localparam int NODE_W       = 8;
  localparam int SYM_W        = 8;
  localparam int BYTE_W       = 8;
  localparam int CNT_W        = $clog2(BYTE_W + 1);

  // symbols per half
  localparam int HALF_LENGTH  = 1 << 11;
  localparam int LEFT_W       = $clog2(HALF_LENGTH + 1);

  // input kinds
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH
  } ttbd_state_t;

  // walker -> reconstruction
  typedef struct packed {
    logic             push;      // new leaf symbol enters the pending slot
    logic             flush;     // pending slot leaves as last of the byte
    logic [SYM_W-1:0] leaf_sym;
    logic             half;
    logic             half_end;
    logic             buf_done;
  } ttbd_evt_t;

  // reconstruction -> walker
  typedef struct packed {
    logic pend_valid;
    logic slot_free;
  } ttbd_stat_t;

  // entry index for a step from node on bit b, wrapped to the table size
  function automatic logic [IDX_W-1:0] lookup_idx(input logic [NODE_W-1:0] node,
                                                  input logic b);
    logic [NODE_W:0] t;
    t = {node, b};
    return IDX_W'(t);
  endfunction

endpackage

>>> src/ttbd_ram.sv
module ttbd_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/ttbd_walk.sv
module ttbd_walk (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_cmd,
  input  logic                            in_sel,
  input  logic [ttbd_pkg::IDX_W-1:0]      in_idx,
  input  logic [ttbd_pkg::ENTRY_W-1:0]    in_val,
  input  logic [ttbd_pkg::BYTE_W-1:0]     in_byte,
  output logic                            ram_we,
  output logic [ttbd_pkg::ADDR_W-1:0]     ram_addr,
  output logic [ttbd_pkg::ENTRY_W-1:0]    ram_wdata,
  input  logic [ttbd_pkg::ENTRY_W-1:0]    ram_rdata,
  input  ttbd_pkg::ttbd_stat_t            stat,
  output ttbd_pkg::ttbd_evt_t             evt
);

  import ttbd_pkg::*;

  localparam logic [LEFT_W-1:0] LEFT_INIT = LEFT_W'(HALF_LENGTH);
  localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(BYTE_W);
  localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);

  ttbd_state_t        state, state_next;
  logic [ADDR_W-1:0]  addr_q, addr_next;
  logic [BYTE_W-2:0]  shreg, shreg_next;   // bits still to walk, next one on top
  logic [CNT_W-1:0]   cnt, cnt_next;       // bits left incl. the one under lookup
  logic [NODE_W-1:0]  node, node_next;
  logic               half, half_next;
  logic [LEFT_W-1:0]  left, left_next;

  logic               leaf;
  logic               last_bit;
  logic               end_half;
  logic               can_push;
  logic [ENTRY_W-1:0] neg;

  assign leaf     = (ram_rdata == '0) || ram_rdata[ENTRY_W-1];
  assign neg      = ENTRY_W'(0) - ram_rdata;
  assign last_bit = (cnt == CNT_ONE);
  assign end_half = (left == LEFT_W'(1));
  assign can_push = !stat.pend_valid || stat.slot_free;
  assign ram_addr = addr_next;
  assign ram_wdata = in_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      node  <= ROOT;
      half  <= 1'b0;
      left  <= LEFT_INIT;
      cnt   <= '0;
    end else begin
      state <= state_next;
      node  <= node_next;
      half  <= half_next;
      left  <= left_next;
      cnt   <= cnt_next;
    end
    addr_q <= addr_next;
    shreg  <= shreg_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_DATA) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (leaf) begin
          if (can_push && (end_half || last_bit)) state_next = ST_FLUSH;
        end else if (last_bit) begin
          state_next = stat.pend_valid ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (stat.slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    ram_we       = 1'b0;
    addr_next    = addr_q;
    shreg_next   = shreg;
    cnt_next     = cnt;
    node_next    = node;
    half_next    = half;
    left_next    = left;
    evt          = '0;
    evt.leaf_sym = neg[SYM_W-1:0];
    evt.half     = half;
    evt.half_end = end_half;
    evt.buf_done = end_half && half;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == CMD_LOAD) begin
            // every 9-bit index is inside the table
            ram_we    = 1'b1;
            addr_next = {in_sel, in_idx};
          end else begin
            addr_next  = {half, lookup_idx(node, in_byte[BYTE_W-1])};
            shreg_next = in_byte[BYTE_W-2:0];
            cnt_next   = CNT_FULL;
          end
        end
      end
      ST_EVAL: begin
        if (!leaf) begin
          node_next = ram_rdata[NODE_W-1:0];
          if (!last_bit) begin
            addr_next  = {half, lookup_idx(ram_rdata[NODE_W-1:0], shreg[BYTE_W-2])};
            shreg_next = {shreg[BYTE_W-3:0], 1'b0};
            cnt_next   = cnt - CNT_ONE;
          end
        end else if (can_push) begin
          evt.push  = 1'b1;
          node_next = ROOT;
          left_next = left - LEFT_W'(1);
          if (end_half) begin
            // rest of the byte is dropped; next half (or next buffer) starts
            half_next = ~half;
            left_next = LEFT_INIT;
          end else if (!last_bit) begin
            addr_next  = {half, lookup_idx(ROOT, shreg[BYTE_W-2])};
            shreg_next = {shreg[BYTE_W-3:0], 1'b0};
            cnt_next   = cnt - CNT_ONE;
          end
        end
        // stalled on a leaf: addr_q is read again so ram_rdata holds
      end
      ST_FLUSH: begin
        evt.flush = stat.slot_free;
      end
      default: ;
    endcase
  end

endmodule

>>> src/ttbd_recon.sv
module ttbd_recon (
  input  logic                          clk,
  input  logic                          rst,
  input  ttbd_pkg::ttbd_evt_t           evt,
  output ttbd_pkg::ttbd_stat_t          stat,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ttbd_pkg::SYM_W-1:0]    m_tdata,
  output logic [1:0]                    m_tuser,
  output logic                          m_tlast
);

  import ttbd_pkg::*;

  logic [SYM_W-1:0] prev;
  logic [SYM_W-1:0] prev_next;
  logic             pend_valid;
  logic [SYM_W-1:0] pend_sym;
  logic             pend_half;
  logic             pend_done;
  logic             slot_free;
  logic             move;

  assign slot_free = !m_tvalid || m_tready;
  assign move      = (evt.push && pend_valid) || evt.flush;
  assign prev_next = evt.half ? (prev ^ evt.leaf_sym) : (prev + evt.leaf_sym);

  assign stat.pend_valid = pend_valid;
  assign stat.slot_free  = slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev       <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      if (evt.push) begin
        prev       <= evt.half_end ? '0 : prev_next;
        pend_valid <= 1'b1;
      end else if (evt.flush) begin
        pend_valid <= 1'b0;
      end
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (evt.push) begin
      pend_sym  <= prev_next;
      pend_half <= evt.half;
      pend_done <= evt.buf_done;
    end
    if (move) begin
      m_tdata <= pend_sym;
      m_tuser <= {pend_done, pend_half};
      m_tlast <= evt.flush;
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    evt.push && pend_valid |-> slot_free)
    else $error("pending symbol overwritten while output busy");

  a_flush_has_data: assert property (@(posedge clk) disable iff (rst)
    evt.flush |-> pend_valid && slot_free)
    else $error("flush without pending symbol or free output");

  a_push_flush_excl: assert property (@(posedge clk) disable iff (rst)
    !(evt.push && evt.flush))
    else $error("push and flush in the same cycle");

  a_move_loads: assert property (@(posedge clk) disable iff (rst)
    move |=> m_tvalid)
    else $error("output register not loaded after move");

endmodule

>>> src/tree_table_bit_decoder_delta.sv
// Load transaction: written in the idle state. Data transaction: accepted in the idle state,
// then one table lookup per bit walked (all 8 bits, fewer when a half ends mid-byte), then
// a flush state hands over the byte's last symbol if it has any; a busy output holds the walk,
// and no new transaction is taken until the byte is done. A symbol leaves once the next leaf
// is found or its byte ends. Reset (rst, synchronous) returns the walk
// to tree 0, node 1, full half, running symbol 0 and empties the output; tables are kept.
module tree_table_bit_decoder_delta (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // entry_index[8:0], entry_value[17:9], data_byte[25:18]
  input  logic [1:0]  s_tuser,   // cmd[0], tree_select[1]
  // decoded symbols
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // symbol[7:0]
  output logic [1:0]  m_tuser,   // second_half[0], buffer_done[1]
  output logic        m_tlast    // last symbol of this input byte
);

  import ttbd_pkg::*;

  // input field positions in s_tdata
  localparam int IDX_LO  = 0;
  localparam int VAL_LO  = IDX_LO + IDX_W;
  localparam int BYTE_LO = VAL_LO + ENTRY_W;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  ttbd_evt_t          evt;
  ttbd_stat_t         stat;

  // both trees share one RAM: tree number is the top address bit
  ttbd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // bit-serial walker: byte shift register, node, half and symbol count
  ttbd_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tuser[0]),
    .in_sel    (s_tuser[1]),
    .in_idx    (s_tdata[VAL_LO-1:IDX_LO]),
    .in_val    (s_tdata[BYTE_LO-1:VAL_LO]),
    .in_byte   (s_tdata[BYTE_LO+BYTE_W-1:BYTE_LO]),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata),
    .stat      (stat),
    .evt       (evt)
  );

  // delta reconstruction, one-symbol hold-back for tlast, output register
  ttbd_recon u_recon (
    .clk      (clk),
    .rst      (rst),
    .evt      (evt),
    .stat     (stat),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ttbd_pkg::*;

  // one decoded symbol as it leaves the block
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             second_half;
    logic             run_last;
    logic             buffer_done;
  } symbol_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // entry_index[8:0], entry_value[17:9], data_byte[25:18]
  logic [1:0]  s_tuser = '0;   // cmd[0], tree_select[1]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // symbol[7:0]
  logic [1:0]  m_tuser;        // second_half[0], buffer_done[1]
  logic        m_tlast;

  tree_table_bit_decoder_delta dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // idle rates in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // shadow copy of the decoder: both tables plus the walk state
  logic [ENTRY_W-1:0] tree_copy    [0:1][0:TREE_ENTRIES-1];
  bit                 written_copy [0:1][0:TREE_ENTRIES-1];
  logic [NODE_W-1:0]  walk_node     = 8'd1;
  logic [SYM_W-1:0]   run_symbol    = '0;
  logic               walk_half     = 1'b0;
  int                 symbols_left  = HALF_LENGTH;
  int                 half_ends     = 0;
  int                 buffers_seen  = 0;

  symbol_t expected_symbols [$];
  int      error_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver: random back-pressure, redrawn every cycle
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic report_error(string msg);
    error_count++;
    if (error_count <= 10)
      $display("%s", msg);
  endtask

  // leaf code for symbol s: the 9-bit two's complement of -s
  function automatic logic [ENTRY_W-1:0] leaf_code(int unsigned s);
    return ENTRY_W'(0 - s);
  endfunction

  // a pointer may only target a node whose two entries are both written,
  // so that the walk never reads an entry that was never loaded
  function automatic bit node_ready(logic sel, logic [NODE_W-1:0] v);
    return written_copy[sel][{v, 1'b0}] && written_copy[sel][{v, 1'b1}];
  endfunction

  function automatic logic [ENTRY_W-1:0] random_entry(logic sel);
    logic [NODE_W-1:0] v;
    v = 8'($urandom_range(1, 255));
    if ($urandom_range(1) == 0 || !node_ready(sel, v))
      return leaf_code($urandom_range(255));
    return {1'b0, v};
  endfunction

  // Walks one compressed byte MSB first through the shadow tables and queues
  // the symbols it yields. A half ending drops the rest of the byte.
  function automatic void decode_byte(logic [BYTE_W-1:0] data);
    symbol_t            run [0:7];
    symbol_t            item;
    int                 count;
    int                 i;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] raw;
    logic [SYM_W-1:0]   leaf_sym;
    bit                 stop;
    count = 0;
    stop  = 1'b0;
    for (i = BYTE_W - 1; i >= 0; i--) begin
      if (!stop) begin
        idx = {walk_node, data[i]};
        raw = tree_copy[walk_half][idx];
        if (raw != '0 && !raw[ENTRY_W-1]) begin
          walk_node = raw[NODE_W-1:0];
        end else begin
          leaf_sym = SYM_W'(ENTRY_W'(0) - raw);
          if (walk_half)
            run_symbol = run_symbol ^ leaf_sym;
          else
            run_symbol = run_symbol + leaf_sym;
          item.symbol      = run_symbol;
          item.second_half = walk_half;
          item.run_last    = 1'b0;
          item.buffer_done = 1'b0;
          walk_node = 8'd1;
          symbols_left--;
          if (symbols_left == 0) begin
            stop = 1'b1;
            half_ends++;
            if (walk_half) begin
              item.buffer_done = 1'b1;
              buffers_seen++;
            end
            walk_half    = ~walk_half;
            run_symbol   = '0;
            symbols_left = HALF_LENGTH;
          end
          run[count] = item;
          count++;
        end
      end
    end
    for (i = 0; i < count; i++) begin
      item = run[i];
      item.run_last = (i == count - 1);
      expected_symbols.push_back(item);
    end
  endfunction

  // Drives one transaction and holds it until accepted; tvalid is only
  // dropped when a gap is wanted, so back-to-back items keep it high.
  task automatic send_item(logic cmd, logic sel, logic [IDX_W-1:0] idx,
                           logic [ENTRY_W-1:0] val, logic [BYTE_W-1:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, data, val, idx};
    s_tuser  <= {sel, cmd};
    do @(posedge clk); while (!s_tready);
    // accepted at this edge: update the shadow state in transaction order
    if (cmd == CMD_LOAD) begin
      if (idx < TREE_ENTRIES) begin
        tree_copy[sel][idx]    = val;
        written_copy[sel][idx] = 1'b1;
      end
    end else begin
      decode_byte(data);
    end
  endtask

  task automatic load_entry(logic sel, logic [IDX_W-1:0] idx, logic [ENTRY_W-1:0] val);
    send_item(CMD_LOAD, sel, idx, val, 8'($urandom));
  endtask

  // payload fields unused by a data item carry junk on purpose
  task automatic send_byte(logic [BYTE_W-1:0] data);
    send_item(CMD_DATA, 1'($urandom), 9'($urandom), 9'($urandom), data);
  endtask

  // Builds a random tree bottom-up: children are written before any pointer
  // to them, the root last. Occasional pointers back to the root make loops.
  task automatic grow_tree(logic sel, int n_nodes, int leaf_pct);
    logic [NODE_W-1:0]  ids [0:15];
    bit                 taken [0:255];
    logic [NODE_W-1:0]  v;
    logic [ENTRY_W-1:0] val;
    int                 k;
    int                 b;
    for (k = 0; k < 256; k++)
      taken[k] = 1'b0;
    for (k = 0; k < n_nodes; k++) begin
      do v = 8'($urandom_range(2, 255)); while (taken[v]);
      taken[v] = 1'b1;
      ids[k]   = v;
    end
    ids[n_nodes] = 8'd1;
    for (k = 0; k <= n_nodes; k++) begin
      for (b = 0; b < 2; b++) begin
        if (node_ready(sel, 8'd1) && $urandom_range(9) == 0)
          val = 9'd1;
        else if (k == 0 || $urandom_range(99) < leaf_pct)
          val = leaf_code($urandom_range(255));
        else
          val = {1'b0, ids[$urandom_range(k - 1)]};
        load_entry(sel, {ids[k], b[0]}, val);
      end
    end
  endtask

  // -- test tasks ---------------------------------------------------------

  // depth-one trees on both tables, extremes of the compressed byte
  task automatic test_root_leaves;
    load_entry(1'b0, 9'd2, leaf_code(0));
    load_entry(1'b0, 9'd3, leaf_code(255));
    load_entry(1'b1, 9'd2, leaf_code(1));
    load_entry(1'b1, 9'd3, leaf_code(128));
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
  endtask

  // table extremes: entries 0/1 (never walked) and 511, the deepest node
  // number, the out-of-range leaf code, and a load landing mid-walk
  task automatic test_entry_extremes;
    load_entry(1'b0, 9'd0, 9'd255);
    load_entry(1'b0, 9'd1, leaf_code(255));
    load_entry(1'b0, 9'd511, 9'h100);     // leaf beyond -255: symbol 0
    load_entry(1'b0, 9'd510, 9'd1);       // back to the root
    load_entry(1'b0, 9'd3, 9'd255);       // root right child -> node 255
    send_byte(8'hFF);
    send_byte(8'h55);                     // ends parked on node 255
    load_entry(1'b1, 9'd511, leaf_code(77));
    send_byte(8'h80);                     // walk resumes from node 255
    send_byte(8'hAA);
  endtask

  // mostly data bytes through freshly grown trees, with noise loads and the
  // odd regrowth between bytes
  task automatic test_random_traffic(int send_pct, int recv_pct, int n_items);
    int k;
    int r;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    grow_tree(1'b0, $urandom_range(1, 12), $urandom_range(30, 80));
    grow_tree(1'b1, $urandom_range(1, 12), $urandom_range(30, 80));
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(99);
      if (r < 78) begin
        send_byte(8'($urandom));
      end else if (r < 96) begin
        r = $urandom_range(1);
        load_entry(r[0], 9'($urandom), random_entry(r[0]));
      end else begin
        r = $urandom_range(1);
        grow_tree(r[0], $urandom_range(1, 6), $urandom_range(30, 80));
      end
    end
  endtask

  // Shallow trees and zero-heavy bytes burn through symbols quickly, so the
  // run crosses into the second half; the uneven code lengths make the half
  // end fall part-way through a byte.
  task automatic test_buffer_wrap;
    int mark;
    int k;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (k = 0; k < 2; k++) begin
      load_entry(k[0], 9'd4, leaf_code($urandom_range(255)));
      load_entry(k[0], 9'd5, leaf_code($urandom_range(255)));
      load_entry(k[0], 9'd2, leaf_code($urandom_range(255)));
      load_entry(k[0], 9'd3, 9'd2);
    end
    mark = half_ends;
    while (half_ends < mark + 1)
      send_byte(8'($urandom & $urandom));
    for (k = 0; k < 8; k++)
      send_byte(8'($urandom));
  endtask

  // -- output checking ----------------------------------------------------

  symbol_t want;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_symbols.size() == 0) begin
        report_error($sformatf("unexpected symbol %02h tuser %b tlast %b",
                               m_tdata, m_tuser, m_tlast));
      end else begin
        want = expected_symbols.pop_front();
        if (m_tdata !== want.symbol || m_tuser[0] !== want.second_half ||
            m_tlast !== want.run_last || m_tuser[1] !== want.buffer_done)
          report_error($sformatf(
            "mismatch: exp sym %02h half %b last %b done %b, got %02h %b %b %b",
            want.symbol, want.second_half, want.run_last, want.buffer_done,
            m_tdata, m_tuser[0], m_tlast, m_tuser[1]));
      end
    end
  end

  // -- sequence -----------------------------------------------------------

  initial begin
    int guard;
    for (int s = 0; s < 2; s++)
      for (int e = 0; e < TREE_ENTRIES; e++) begin
        tree_copy[s][e]    = '0;
        written_copy[s][e] = 1'b0;
      end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    send_idle_pct = 28;
    recv_idle_pct = 69;
    test_root_leaves;
    test_entry_extremes;
    test_random_traffic(28, 69, 50);
    test_random_traffic(69, 28, 50);
    test_random_traffic(0, 0, 50);
    test_buffer_wrap;
    s_tvalid <= 1'b0;

    // drain, then give the block time to show any stray transaction
    guard = 0;
    while (expected_symbols.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (40) @(posedge clk);
    if (expected_symbols.size() != 0)
      report_error($sformatf("%0d expected symbols never arrived",
                             expected_symbols.size()));

    if (error_count == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
